>>> hdl/salc_pkg.sv
// ============================================================================
// salc_pkg: shared types and constants of the set-associative LRU cache model
// Field widths, configuration register codes, outcome codes, sequencer states
// and the result record of the shared compare unit.
// ============================================================================
package salc_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_WIDTH_DEF   = 64;

    // Fixed field widths
    localparam int ADDR_FIELD_W = 64;
    localparam int OUTCOME_W    = 2;
    localparam int TALLY_W      = 32;
    localparam int STAMP_W      = 64;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 104;
    localparam int M_PAD_W      = M_TDATA_W - OUTCOME_W - 3 * TALLY_W;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_W       = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_BITS   = 2'd0,
        REG_BLOCK_BITS = 2'd1,
        REG_WAYS       = 2'd2
    } cfg_reg_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_ADDR  = 3'd2,
        ST_SCAN  = 3'd3,
        ST_WRITE = 3'd4
    } state_t;

    // Result of comparing one way against the lookup
    typedef struct packed {
        logic hit;    // valid and tag matches
        logic empty;  // way not valid
        logic older;  // stamp below the best stamp so far
    } cmp_res_t;

endpackage

>>> hdl/salc_mem.sv
// ============================================================================
// salc_mem: set row memory
// One row per set, one write port and one read port, read data registered.
// ============================================================================
module salc_mem #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/salc_cmp.sv
// ============================================================================
// salc_cmp: shared way compare unit
// Match one way's tag against the lookup tag and its stamp against the oldest.
// ============================================================================
module salc_cmp #(
    parameter int TAG_W = 64
) (
    input  logic                         line_valid,
    input  logic [TAG_W-1:0]             line_tag,
    input  logic [salc_pkg::STAMP_W-1:0] line_stamp,
    input  logic [TAG_W-1:0]             look_tag,
    input  logic [salc_pkg::STAMP_W-1:0] best_stamp,
    output salc_pkg::cmp_res_t           res
);

    always_comb begin
        res.hit   = line_valid && (line_tag == look_tag);
        res.empty = !line_valid;
        res.older = line_stamp < best_stamp;
    end

endmodule

>>> hdl/set_assoc_lru_cache_model_top.sv
// ============================================================================
// set_assoc_lru_cache_model_top: set-associative cache directory, LRU policy
// Looks up one address per item and returns hit/fill/evict plus running totals.
// ============================================================================
// Each input item carries one address. The set index is taken from the bits
// just above block_bits offset bits, the tag is every bit above the set index.
// A hit refreshes the way's use stamp; a miss fills the lowest invalid way, or
// when the set is full evicts the way with the oldest stamp (lowest way on a
// tie). Each result item carries the outcome and saturating hit, miss and
// eviction totals. After reset a clearing pass writes every set row once,
// with s_axis_tready low. Then an item is accepted, its address split, its
// set row read and its ways scanned: all active ways on a miss, the ways up
// to the hit way on a hit. The single compare unit checks one way per cycle
// against the set row read from memory. The chosen way is written back
// once the output register is free. The result waits in an output
// register, so the next item is accepted while it is still held; a new result
// is loaded only once the previous one has been taken. Configuration writes
// are taken at any time, but must only be issued while the block is idle.
// ============================================================================
module set_assoc_lru_cache_model_top #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [salc_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [63:0] address
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [salc_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [1:0] outcome,
                                                            // [33:2] hits_total,
                                                            // [65:34] misses_total,
                                                            // [97:66] evictions_total
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_W   = MAX_SET_BITS;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENTRY_W = 1 + ADDR_WIDTH + salc_pkg::STAMP_W;
    localparam int ROW_W   = MAX_WAYS * ENTRY_W;
    localparam int SB_W    = 4;                              // holds MAX_SET_BITS
    localparam int SHAMT_W = salc_pkg::BLOCK_BITS_W + 1;
    localparam int EFF_W   = salc_pkg::WAYS_W + 1;           // holds MAX_WAYS
    localparam int STAMP_W = salc_pkg::STAMP_W;
    localparam int TALLY_W = salc_pkg::TALLY_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [salc_pkg::SET_BITS_W-1:0]   set_bits_reg;
    logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_reg;
    logic [salc_pkg::WAYS_W-1:0]       ways_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= salc_pkg::SET_BITS_W'(1);
            block_bits_reg <= salc_pkg::BLOCK_BITS_W'(1);
            ways_reg       <= salc_pkg::WAYS_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                salc_pkg::REG_SET_BITS:   set_bits_reg   <= cfg_data[salc_pkg::SET_BITS_W-1:0];
                salc_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg_data;
                salc_pkg::REG_WAYS:       ways_reg       <= cfg_data[salc_pkg::WAYS_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    salc_pkg::state_t state_reg, state_next;
    logic [SET_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [ADDR_WIDTH-1:0] tag_reg, tag_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [WAY_W-1:0]      way_cnt_reg, way_cnt_next;
    logic                  hit_reg, hit_next;
    logic                  empty_seen_reg, empty_seen_next;
    logic [WAY_W-1:0]      empty_way_reg, empty_way_next;
    logic [WAY_W-1:0]      victim_reg, victim_next;
    logic [STAMP_W-1:0]    best_stamp_reg, best_stamp_next;
    logic [STAMP_W-1:0]    stamp_reg, stamp_next;
    logic [TALLY_W-1:0]    hit_tally_reg, hit_tally_next;
    logic [TALLY_W-1:0]    miss_tally_reg, miss_tally_next;
    logic [TALLY_W-1:0]    evict_tally_reg, evict_tally_next;
    salc_pkg::outcome_t    outcome_reg, outcome_next;
    logic                  m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------
    // Address split: set index and tag from the held address
    // ------------------------------------------------------------------
    logic [SB_W-1:0]       sb;
    logic [SET_W-1:0]      set_mask;
    logic [ADDR_WIDTH-1:0] addr_shifted;
    logic [SHAMT_W-1:0]    tag_shamt;
    logic [SET_W-1:0]      set_calc;
    logic [ADDR_WIDTH-1:0] tag_calc;

    always_comb begin
        // saturate set bits to the implemented set count
        sb = ({1'b0, set_bits_reg} > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                          : {1'b0, set_bits_reg};
        set_mask     = ~({SET_W{1'b1}} << sb);
        addr_shifted = addr_reg >> block_bits_reg;
        set_calc     = addr_shifted[SET_W-1:0] & set_mask;
        // a shift at or past the address width leaves a zero tag
        tag_shamt    = SHAMT_W'(block_bits_reg) + SHAMT_W'(sb);
        tag_calc     = addr_reg >> tag_shamt;
    end

    // active way count, clamped to 1..MAX_WAYS
    logic [EFF_W-1:0] eff_ways;
    logic [WAY_W-1:0] last_way;

    always_comb begin
        if (ways_reg == '0) begin
            eff_ways = EFF_W'(1);
        end else if ({1'b0, ways_reg} > EFF_W'(MAX_WAYS)) begin
            eff_ways = EFF_W'(MAX_WAYS);
        end else begin
            eff_ways = {1'b0, ways_reg};
        end
        last_way = WAY_W'(eff_ways - EFF_W'(1));
    end

    // ------------------------------------------------------------------
    // Set row memory: each way is {valid, tag, stamp}
    // ------------------------------------------------------------------
    logic [MAX_WAYS-1:0][ENTRY_W-1:0] rd_row;
    logic [MAX_WAYS-1:0][ENTRY_W-1:0] wr_row;
    logic                             mem_wr_en;
    logic [SET_W-1:0]                 mem_wr_addr;
    logic                             mem_rd_en;
    logic [ROW_W-1:0]                 rd_row_flat;

    salc_mem #(
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (wr_row),
        .rd_en   (mem_rd_en),
        .rd_addr (set_calc),
        .rd_data (rd_row_flat)
    );

    assign rd_row = rd_row_flat;

    // ------------------------------------------------------------------
    // Shared compare unit, one way per cycle
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0]    cur_entry;
    logic                  cur_valid;
    logic [ADDR_WIDTH-1:0] cur_tag;
    logic [STAMP_W-1:0]    cur_stamp;
    salc_pkg::cmp_res_t    cmp_res;

    assign cur_entry = rd_row[way_cnt_reg];
    assign cur_valid = cur_entry[ENTRY_W-1];
    assign cur_tag   = cur_entry[STAMP_W +: ADDR_WIDTH];
    assign cur_stamp = cur_entry[STAMP_W-1:0];

    salc_cmp #(
        .TAG_W (ADDR_WIDTH)
    ) u_cmp (
        .line_valid (cur_valid),
        .line_tag   (cur_tag),
        .line_stamp (cur_stamp),
        .look_tag   (tag_reg),
        .best_stamp (best_stamp_reg),
        .res        (cmp_res)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic             out_free;
    logic [WAY_W-1:0] way_sel;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign way_sel  = hit_reg        ? way_cnt_reg   :
                      empty_seen_reg ? empty_way_reg : victim_reg;

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        addr_next        = addr_reg;
        tag_next         = tag_reg;
        set_next         = set_reg;
        way_cnt_next     = way_cnt_reg;
        hit_next         = hit_reg;
        empty_seen_next  = empty_seen_reg;
        empty_way_next   = empty_way_reg;
        victim_next      = victim_reg;
        best_stamp_next  = best_stamp_reg;
        stamp_next       = stamp_reg;
        hit_tally_next   = hit_tally_reg;
        miss_tally_next  = miss_tally_reg;
        evict_tally_next = evict_tally_reg;
        outcome_next     = outcome_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        s_axis_tready    = 1'b0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = set_reg;
        mem_rd_en        = 1'b0;
        wr_row           = rd_row;

        case (state_reg)
            salc_pkg::ST_CLEAR: begin
                // zero one set row per cycle after reset
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                wr_row       = '0;
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (&clr_cnt_reg) begin
                    state_next = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    addr_next  = s_axis_tdata[ADDR_WIDTH-1:0];
                    state_next = salc_pkg::ST_ADDR;
                end
            end
            salc_pkg::ST_ADDR: begin
                // split the address, fetch the set row, arm the scan
                mem_rd_en       = 1'b1;
                set_next        = set_calc;
                tag_next        = tag_calc;
                way_cnt_next    = '0;
                hit_next        = 1'b0;
                empty_seen_next = 1'b0;
                state_next      = salc_pkg::ST_SCAN;
            end
            salc_pkg::ST_SCAN: begin
                if (cmp_res.hit) begin
                    // hold the way counter on the hit way
                    hit_next   = 1'b1;
                    state_next = salc_pkg::ST_WRITE;
                end else begin
                    if (cmp_res.empty && !empty_seen_reg) begin
                        empty_seen_next = 1'b1;
                        empty_way_next  = way_cnt_reg;
                    end
                    // strict compare keeps the lowest way among equal stamps
                    if (way_cnt_reg == '0 || cmp_res.older) begin
                        victim_next     = way_cnt_reg;
                        best_stamp_next = cur_stamp;
                    end
                    if (way_cnt_reg == last_way) begin
                        state_next = salc_pkg::ST_WRITE;
                    end else begin
                        way_cnt_next = way_cnt_reg + WAY_W'(1);
                    end
                end
            end
            salc_pkg::ST_WRITE: begin
                if (out_free) begin
                    mem_wr_en       = 1'b1;
                    wr_row[way_sel] = {1'b1, tag_reg, stamp_reg};
                    stamp_next      = stamp_reg + STAMP_W'(1);
                    if (hit_reg) begin
                        outcome_next = salc_pkg::OUT_HIT;
                        if (hit_tally_reg != salc_pkg::TALLY_MAX) begin
                            hit_tally_next = hit_tally_reg + TALLY_W'(1);
                        end
                    end else begin
                        if (miss_tally_reg != salc_pkg::TALLY_MAX) begin
                            miss_tally_next = miss_tally_reg + TALLY_W'(1);
                        end
                        if (empty_seen_reg) begin
                            outcome_next = salc_pkg::OUT_FILL;
                        end else begin
                            outcome_next = salc_pkg::OUT_EVICT;
                            if (evict_tally_reg != salc_pkg::TALLY_MAX) begin
                                evict_tally_next = evict_tally_reg + TALLY_W'(1);
                            end
                        end
                    end
                    m_valid_next = 1'b1;
                    state_next   = salc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = salc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= salc_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            stamp_reg       <= STAMP_W'(1);
            hit_tally_reg   <= '0;
            miss_tally_reg  <= '0;
            evict_tally_reg <= '0;
            m_valid_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            empty_seen_reg  <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            stamp_reg       <= stamp_next;
            hit_tally_reg   <= hit_tally_next;
            miss_tally_reg  <= miss_tally_next;
            evict_tally_reg <= evict_tally_next;
            m_valid_reg     <= m_valid_next;
            hit_reg         <= hit_next;
            empty_seen_reg  <= empty_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        tag_reg        <= tag_next;
        set_reg        <= set_next;
        way_cnt_reg    <= way_cnt_next;
        empty_way_reg  <= empty_way_next;
        victim_reg     <= victim_next;
        best_stamp_reg <= best_stamp_next;
        outcome_reg    <= outcome_next;
    end

    // ------------------------------------------------------------------
    // Result item: tallies only change when a new result is loaded
    // ------------------------------------------------------------------
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{salc_pkg::M_PAD_W{1'b0}}, evict_tally_reg, miss_tally_reg,
                            hit_tally_reg, outcome_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every eviction is also a miss
    assert property (@(posedge aclk) disable iff (!aresetn)
        miss_tally_reg >= evict_tally_reg)
        else $error("eviction total exceeds miss total");

    // an accepted item goes straight to the address split
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> state_reg == salc_pkg::ST_ADDR)
        else $error("accepted item did not start a lookup");

    // the access stamp only advances with a write-back
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(stamp_reg) |-> $past(state_reg == salc_pkg::ST_WRITE))
        else $error("access stamp moved outside write-back");

    // a result is only loaded from write-back
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid_reg) |-> $past(state_reg == salc_pkg::ST_WRITE))
        else $error("result loaded outside write-back");

endmodule
